// ===== src/supl_pkg.sv =====
`default_nettype none

package supl_pkg;

    localparam int DEPTH_DEF = 128;
    localparam int PRI_W     = 16;
    localparam int ID_W      = 16;
    localparam int RANK_W    = 7;
    localparam int COUNT_W   = 8;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_READ   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_FULL     = 3'd1,
        ST_READ_OK  = 3'd2,
        ST_READ_OOR = 3'd3,
        ST_CLEARED  = 3'd4
    } t_status;

    typedef struct packed {
        logic signed [PRI_W-1:0] pri;
        logic        [ID_W-1:0]  id;
    } t_key;

    // true when key a orders strictly after key b
    function automatic logic key_after(input t_key a, input t_key b);
        logic res;
        if (a.pri != b.pri) begin
            res = $signed(a.pri) > $signed(b.pri);
        end else begin
            res = a.id > b.id;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== src/supl_cell.sv =====
`default_nettype none

module supl_cell
    import supl_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_load,
    input  wire logic i_empty,
    input  wire t_key i_new,
    input  wire t_key i_prev,
    input  wire logic i_prev_after,
    output t_key      o_key,
    output logic      o_after
);

    t_key r_key;
    t_key n_key;

    assign o_after = i_empty || key_after(r_key, i_new);
    assign o_key   = r_key;

    // shift from the neighbor, or take the new entry at the insertion point
    always_comb begin
        n_key = r_key;
        if (i_load && o_after) begin
            if (i_prev_after) begin
                n_key = i_prev;
            end else begin
                n_key = i_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

`default_nettype wire

// ===== src/sorted_urgency_priority_list.sv =====
// Sorted priority list of up to DEPTH entries (signed priority, id), kept in
// ascending key order in a row of cells; equal priorities order by smaller id,
// and an equal key goes behind the one already held. Each beat carries one op:
// insert, read at rank, or clear; each gives exactly one result beat, in the
// cycle after acceptance. A beat is taken every cycle while the result register
// is free or being drained: every cell compares its key against the new one in
// parallel and shifts by one, so inserts do not slow down as the list fills.
// Reads select the cell at the given rank; ranks past 127 are not reachable.
`default_nettype none

module sorted_urgency_priority_list
    import supl_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic [1:0]              i_op,
    input  wire logic signed [PRI_W-1:0] i_item_priority,
    input  wire logic [ID_W-1:0]         i_item_id,
    input  wire logic [RANK_W-1:0]       i_read_rank,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic [2:0]                   o_status,
    output logic [COUNT_W-1:0]           o_entry_count,
    output logic signed [PRI_W-1:0]      o_out_priority,
    output logic [ID_W-1:0]              o_out_id
);

    localparam int CW = $clog2(DEPTH + 1);

    logic          r_valid;
    logic          n_valid;
    t_status       r_status;
    t_status       n_status;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [COUNT_W-1:0] r_ecount;
    t_key          r_out;
    t_key          n_out;

    logic          w_accept;
    logic          w_full;
    logic          w_load;
    logic          w_rd_ok;
    t_key          w_new;
    t_key          w_rd;
    t_key          w_key   [DEPTH];
    logic          w_after [DEPTH];
    logic          w_hit   [DEPTH];
    logic [CW+COUNT_W-1:0] w_count_ext;

    assign o_ready  = !r_valid || i_ready;
    assign w_accept = i_valid && o_ready;
    assign w_full   = r_count >= CW'(DEPTH);
    assign w_load   = w_accept && (i_op == OP_INSERT) && !w_full;
    assign w_new    = '{pri: i_item_priority, id: i_item_id};
    assign w_rd_ok  = (CW+RANK_W)'(i_read_rank) < (CW+RANK_W)'(r_count);

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        if (i == 0) begin : g_head
            supl_cell u_cell (
                .i_clk        (i_clk),
                .i_load       (w_load),
                .i_empty      (CW'(i) >= r_count),
                .i_new        (w_new),
                .i_prev       (w_new),
                .i_prev_after (1'b0),
                .o_key        (w_key[i]),
                .o_after      (w_after[i])
            );
        end else begin : g_body
            supl_cell u_cell (
                .i_clk        (i_clk),
                .i_load       (w_load),
                .i_empty      (CW'(i) >= r_count),
                .i_new        (w_new),
                .i_prev       (w_key[i-1]),
                .i_prev_after (w_after[i-1]),
                .o_key        (w_key[i]),
                .o_after      (w_after[i])
            );
        end
        assign w_hit[i] = 32'(i_read_rank) == 32'(i);
    end

    always_comb begin
        w_rd = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (w_hit[k]) begin
                w_rd = w_rd | w_key[k];
            end
        end
    end

    always_comb begin
        n_count  = r_count;
        n_status = ST_READ_OOR;
        n_out    = '0;
        case (i_op)
            OP_INSERT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count  = r_count + 1'b1;
                    n_status = ST_INSERTED;
                end
            end
            OP_READ: begin
                if (w_rd_ok) begin
                    n_status = ST_READ_OK;
                    n_out    = w_rd;
                end
            end
            OP_CLEAR: begin
                n_count  = '0;
                n_status = ST_CLEARED;
            end
            default: begin
                n_status = ST_READ_OOR;
            end
        endcase
    end

    assign w_count_ext = (CW+COUNT_W)'(n_count);

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_count <= '0;
        end else begin
            r_valid <= n_valid;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_ecount <= w_count_ext[COUNT_W-1:0];
            r_out    <= n_out;
        end
    end

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_entry_count  = r_ecount;
    assign o_out_priority = r_out.pri;
    assign o_out_id       = r_out.id;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count exceeds depth");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_op == OP_INSERT) && !w_full) |=> r_count == CW'($past(r_count) + 1'b1))
        else $error("insert did not advance count");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_op == OP_CLEAR)) |=> r_count == '0)
        else $error("clear did not empty list");

    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CW'(2)) |-> !key_after(w_key[0], w_key[1]))
        else $error("head cells out of order");

    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_status != ST_READ_OK)) |-> (r_out == '0))
        else $error("payload not zero on non-read result");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
module tb;
    import supl_pkg::*;

    localparam int LIST_DEPTH  = DEPTH_DEF;
    localparam int CYCLE_LIMIT = 300000;

    typedef struct {
        t_status                 status;
        logic [COUNT_W-1:0]      count;
        logic signed [PRI_W-1:0] pri;
        logic [ID_W-1:0]         id;
    } t_result;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_ready;
    logic [1:0]              i_op;
    logic signed [PRI_W-1:0] i_item_priority;
    logic [ID_W-1:0]         i_item_id;
    logic [RANK_W-1:0]       i_read_rank;
    logic                    o_valid;
    logic                    i_ready;
    logic [2:0]              o_status;
    logic [COUNT_W-1:0]      o_entry_count;
    logic signed [PRI_W-1:0] o_out_priority;
    logic [ID_W-1:0]         o_out_id;

    logic signed [PRI_W-1:0] shadow_pri [LIST_DEPTH];
    logic [ID_W-1:0]         shadow_id [LIST_DEPTH];
    int                      shadow_len;

    t_result pending_results [$];
    t_result head;
    int      status_tally [0:4];
    int      beats_sent;
    int      error_count;
    int      cycle_count;
    bit      tx_idle_en;
    bit      rx_idle_en;
    int      rx_hold;

    sorted_urgency_priority_list #(
        .DEPTH(LIST_DEPTH)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_op(i_op),
        .i_item_priority(i_item_priority),
        .i_item_id(i_item_id),
        .i_read_rank(i_read_rank),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_status(o_status),
        .o_entry_count(o_entry_count),
        .o_out_priority(o_out_priority),
        .o_out_id(o_out_id)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_results.size());
            $display("status: fail");
            $finish;
        end
    end

    function automatic t_result predict_list_op(t_op op, logic signed [PRI_W-1:0] pri,
                                                logic [ID_W-1:0] id,
                                                logic [RANK_W-1:0] rank);
        t_result res;
        int      pos;
        res.pri = '0;
        res.id  = '0;
        case (op)
            OP_INSERT: begin
                if (shadow_len >= LIST_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    pos = shadow_len;
                    while (pos > 0 && ((shadow_pri[pos-1] > pri) ||
                           (shadow_pri[pos-1] == pri && shadow_id[pos-1] > id))) begin
                        shadow_pri[pos] = shadow_pri[pos-1];
                        shadow_id[pos]  = shadow_id[pos-1];
                        pos--;
                    end
                    shadow_pri[pos] = pri;
                    shadow_id[pos]  = id;
                    shadow_len++;
                    res.status = ST_INSERTED;
                end
            end
            OP_READ: begin
                if (int'(rank) < shadow_len) begin
                    res.pri    = shadow_pri[rank];
                    res.id     = shadow_id[rank];
                    res.status = ST_READ_OK;
                end else begin
                    res.status = ST_READ_OOR;
                end
            end
            OP_CLEAR: begin
                shadow_len = 0;
                res.status = ST_CLEARED;
            end
            default: begin
                res.status = ST_READ_OOR;
            end
        endcase
        res.count = COUNT_W'(shadow_len);
        status_tally[res.status]++;
        return res;
    endfunction

    function automatic logic signed [PRI_W-1:0] rand_pri();
        logic signed [PRI_W-1:0] v;
        case ($urandom_range(3))
            0: v = PRI_W'(int'($urandom_range(6)) - 3);
            1: begin
                case ($urandom_range(3))
                    0: v = 16'sh8000;
                    1: v = 16'sh7FFF;
                    2: v = -16'sd1;
                    default: v = 16'sd0;
                endcase
            end
            default: v = PRI_W'($urandom);
        endcase
        return v;
    endfunction

    function automatic logic [ID_W-1:0] rand_id();
        logic [ID_W-1:0] v;
        case ($urandom_range(3))
            0: v = ID_W'($urandom_range(3));
            1: v = ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
            default: v = ID_W'($urandom);
        endcase
        return v;
    endfunction

    task automatic send_beat(t_op op, logic signed [PRI_W-1:0] pri, logic [ID_W-1:0] id,
                             logic [RANK_W-1:0] rank);
        @(negedge i_clk);
        while (tx_idle_en && $urandom_range(99) < 36) begin
            i_valid         <= 1'b0;
            i_op            <= 2'($urandom);
            i_item_priority <= PRI_W'($urandom);
            i_item_id       <= ID_W'($urandom);
            i_read_rank     <= RANK_W'($urandom);
            @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_op            <= op;
        i_item_priority <= pri;
        i_item_id       <= id;
        i_read_rank     <= rank;
        do @(posedge i_clk); while (!o_ready);
        pending_results.push_back(predict_list_op(op, pri, id, rank));
        beats_sent++;
    endtask

    task automatic finish_beats();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_one_mixed(int insert_pct);
        int           r;
        logic [RANK_W-1:0] rank;
        r = $urandom_range(99);
        if (r < insert_pct) begin
            send_beat(OP_INSERT, rand_pri(), rand_id(), RANK_W'($urandom));
        end else begin
            r = $urandom_range(99);
            if (r < 75 && shadow_len > 0) begin
                rank = RANK_W'($urandom_range(shadow_len - 1));
                send_beat(OP_READ, rand_pri(), rand_id(), rank);
            end else if (r < 85) begin
                send_beat(OP_READ, rand_pri(), rand_id(), RANK_W'(shadow_len));
            end else if (r < 93) begin
                send_beat(OP_READ, rand_pri(), rand_id(), RANK_W'($urandom));
            end else if (r < 97) begin
                send_beat(OP_NONE, rand_pri(), rand_id(), RANK_W'($urandom));
            end else begin
                send_beat(OP_CLEAR, rand_pri(), rand_id(), RANK_W'($urandom));
            end
        end
    endtask

    task automatic send_mixed_ops(int n_items);
        int first;
        first = beats_sent;
        while (beats_sent - first < n_items) begin
            if ($urandom_range(99) < 70) begin
                send_beat(OP_CLEAR, rand_pri(), rand_id(), RANK_W'($urandom));
            end
            if ($urandom_range(99) < 8) begin
                while (shadow_len < LIST_DEPTH) send_one_mixed(85);
                repeat ($urandom_range(1, 3)) send_one_mixed(100);
                repeat (4) send_one_mixed(0);
            end else begin
                repeat ($urandom_range(1, 40)) send_one_mixed(55);
            end
        end
    endtask

    task automatic test_empty_list();
        send_beat(OP_READ, 16'sd0, 16'h0000, 7'd0);
        send_beat(OP_READ, 16'sh7FFF, 16'hFFFF, 7'd127);
        send_beat(OP_NONE, 16'sh8000, 16'h1234, 7'd0);
        send_beat(OP_CLEAR, 16'sd5, 16'h0005, 7'd5);
        finish_beats();
    endtask

    task automatic test_extremes_and_ties();
        send_beat(OP_INSERT, 16'sh7FFF, 16'hFFFF, 7'h7F);
        send_beat(OP_INSERT, 16'sh8000, 16'h0000, 7'h00);
        send_beat(OP_INSERT, 16'sd0, 16'h0005, 7'h2A);
        send_beat(OP_INSERT, 16'sd0, 16'h0005, 7'h55);
        send_beat(OP_INSERT, 16'sd0, 16'h0003, 7'h00);
        send_beat(OP_INSERT, 16'sd0, 16'h0009, 7'h00);
        send_beat(OP_INSERT, -16'sd1, 16'hFFFF, 7'h00);
        send_beat(OP_INSERT, 16'sh8000, 16'hFFFF, 7'h00);
        for (int k = 0; k < 8; k++) begin
            send_beat(OP_READ, PRI_W'($urandom), ID_W'($urandom), RANK_W'(k));
        end
        send_beat(OP_READ, 16'sd0, 16'h0000, 7'd8);
        send_beat(OP_READ, 16'sd0, 16'h0000, 7'd127);
        send_beat(OP_NONE, 16'sd7, 16'h0007, 7'd0);
        send_beat(OP_CLEAR, 16'sd0, 16'h0000, 7'd0);
        send_beat(OP_READ, 16'sd0, 16'h0000, 7'd0);
        finish_beats();
    endtask

    task automatic test_fill_to_full();
        for (int k = 0; k < LIST_DEPTH; k++) begin
            send_beat(OP_INSERT, PRI_W'(1000 - k), ID_W'(k), RANK_W'($urandom));
        end
        send_beat(OP_INSERT, 16'sh8000, 16'h0000, 7'd0);
        send_beat(OP_INSERT, 16'sh7FFF, 16'hFFFF, 7'd0);
        send_beat(OP_READ, 16'sd0, 16'h0000, 7'd0);
        send_beat(OP_READ, 16'sd0, 16'h0000, 7'd64);
        send_beat(OP_READ, 16'sd0, 16'h0000, 7'd127);
        send_beat(OP_CLEAR, 16'sd0, 16'h0000, 7'd0);
        send_beat(OP_READ, 16'sd0, 16'h0000, 7'd0);
        finish_beats();
    endtask

    task automatic test_random_mix();
        send_mixed_ops(750);
        finish_beats();
    endtask

    task automatic test_no_idle();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        send_mixed_ops(150);
        finish_beats();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    task automatic test_result_backpressure();
        rx_hold = 300;
        send_mixed_ops(40);
        finish_beats();
    endtask

    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            i_ready <= 1'b0;
            rx_hold = rx_hold - 1;
        end else if (rx_idle_en) begin
            i_ready <= ($urandom_range(99) >= 36);
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                error_count++;
                $error("result beat with nothing pending: status %0d count %0d",
                       o_status, o_entry_count);
            end else begin
                head = pending_results.pop_front();
                if (o_status !== head.status) begin
                    error_count++;
                    $error("status: expected %0d, actual %0d", head.status, o_status);
                end
                if (o_entry_count !== head.count) begin
                    error_count++;
                    $error("entry_count: expected %0d, actual %0d", head.count,
                           o_entry_count);
                end
                if (o_out_priority !== head.pri) begin
                    error_count++;
                    $error("out_priority: expected %0d, actual %0d", head.pri,
                           o_out_priority);
                end
                if (o_out_id !== head.id) begin
                    error_count++;
                    $error("out_id: expected %0d, actual %0d", head.id, o_out_id);
                end
            end
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_op            = OP_INSERT;
        i_item_priority = '0;
        i_item_id       = '0;
        i_read_rank     = '0;
        i_ready         = 1'b0;
        tx_idle_en      = 1'b1;
        rx_idle_en      = 1'b1;
        rx_hold         = 0;
        shadow_len      = 0;
        beats_sent      = 0;
        error_count     = 0;
        cycle_count     = 0;
        foreach (status_tally[k]) status_tally[k] = 0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_list();
        test_extremes_and_ties();
        test_fill_to_full();
        test_random_mix();
        test_no_idle();
        test_result_backpressure();

        repeat (5) @(posedge i_clk);

        $display("%0d beats: %0d inserts, %0d dropped on a full list, %0d clears",
                 beats_sent, status_tally[ST_INSERTED], status_tally[ST_FULL],
                 status_tally[ST_CLEARED]);
        $display("reads: %0d in range, %0d out of range or unused op",
                 status_tally[ST_READ_OK], status_tally[ST_READ_OOR]);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/supl_pkg.sv
src/supl_cell.sv
src/sorted_urgency_priority_list.sv
tb/tb.sv
